@@ rtl/core/pfc_pkg.sv @@
// ----------------------------------------------------------------------------
// Pixel format converter package
// Format codes, register indexes, luma constants and the result record
// shared by the converter datapath and the top level.
// ----------------------------------------------------------------------------
package pfc_pkg;

   // format codes, as written to the target format register
   localparam logic [3:0] FMT_I8       = 4'd0;
   localparam logic [3:0] FMT_AI88     = 4'd1;
   localparam logic [3:0] FMT_RGB888   = 4'd2;
   localparam logic [3:0] FMT_RGBA8888 = 4'd3;
   localparam logic [3:0] FMT_RGB565   = 4'd4;
   localparam logic [3:0] FMT_A8       = 4'd5;
   localparam logic [3:0] FMT_RGBA4444 = 4'd6;
   localparam logic [3:0] FMT_RGB5A1   = 4'd7;
   localparam logic [3:0] FMT_AUTO     = 4'd8;

   // source format codes
   localparam logic [1:0] SRC_I8       = 2'd0;
   localparam logic [1:0] SRC_AI88     = 2'd1;
   localparam logic [1:0] SRC_RGB888   = 2'd2;
   localparam logic [1:0] SRC_RGBA8888 = 2'd3;

   // register indexes
   localparam logic CSR_SOURCE_FORMAT = 1'b0;
   localparam logic CSR_TARGET_FORMAT = 1'b1;

   // luma = (299 R + 587 G + 114 B + 500) / 1000
   localparam int             LUMA_SUM_W  = 18;
   localparam logic [9:0]     LUMA_COEF_R = 10'd299;
   localparam logic [9:0]     LUMA_COEF_G = 10'd587;
   localparam logic [9:0]     LUMA_COEF_B = 10'd114;
   localparam logic [9:0]     LUMA_ROUND  = 10'd500;
   // divide by 1000 as multiply by ceil(2^28 / 1000), exact for sums below 2^18
   localparam int             LUMA_SHIFT  = 28;
   localparam int             LUMA_RECIP_W = 19;
   localparam logic [18:0]    LUMA_RECIP  = 19'd268436;

   typedef struct packed {
      logic [31:0] pixel;
      logic [2:0]  nbytes;
      logic [2:0]  format;
      logic        passed;
   } pfc_result_type;

endpackage

@@ rtl/core/pfc_format.sv @@
// ----------------------------------------------------------------------------
// Pixel format converter datapath
// Finishes the luma division and packs one source pixel into the target
// layout, or falls back to a copy of the source pixel.
// ----------------------------------------------------------------------------
module pfc_format (
   input  logic [1:0]                       src_format,
   input  logic [3:0]                       tgt_format,
   input  logic [31:0]                      src_bytes,
   input  logic [pfc_pkg::LUMA_SUM_W-1:0]   luma_sum,
   output pfc_pkg::pfc_result_type          result
);

   localparam int PROD_W = pfc_pkg::LUMA_SUM_W + pfc_pkg::LUMA_RECIP_W;

   logic [PROD_W-1:0] luma_prod;
   logic [7:0]        luma;
   logic [7:0]        b0, b1, b2, b3;
   logic [7:0]        r, g, b, a;
   logic              has_alpha;
   logic              ok;
   logic [31:0]       conv_pixel;
   logic [2:0]        conv_nbytes;
   logic [31:0]       copy_pixel;

   assign luma_prod = PROD_W'(luma_sum) * PROD_W'(pfc_pkg::LUMA_RECIP);
   assign luma      = luma_prod[pfc_pkg::LUMA_SHIFT +: 8];

   assign b0 = src_bytes[7:0];
   assign b1 = src_bytes[15:8];
   assign b2 = src_bytes[23:16];
   assign b3 = src_bytes[31:24];

   assign has_alpha = src_format[0];

   always_comb begin
      if (src_format == pfc_pkg::SRC_I8 || src_format == pfc_pkg::SRC_AI88) begin
         r = b0;
         g = b0;
         b = b0;
         a = (src_format == pfc_pkg::SRC_AI88) ? b1 : 8'hFF;
      end else begin
         r = b0;
         g = b1;
         b = b2;
         a = (src_format == pfc_pkg::SRC_RGBA8888) ? b3 : 8'hFF;
      end
   end

   always_comb begin
      ok          = (tgt_format != {2'b00, src_format}) && !tgt_format[3];
      conv_pixel  = '0;
      conv_nbytes = 3'd2;
      unique case (tgt_format)
         pfc_pkg::FMT_I8: begin
            conv_pixel  = {24'd0, luma};
            conv_nbytes = 3'd1;
         end
         pfc_pkg::FMT_AI88: begin
            conv_pixel  = {16'd0, a, luma};
         end
         pfc_pkg::FMT_RGB888: begin
            conv_pixel  = {8'd0, b, g, r};
            conv_nbytes = 3'd3;
         end
         pfc_pkg::FMT_RGBA8888: begin
            conv_pixel  = {a, b, g, r};
            conv_nbytes = 3'd4;
         end
         pfc_pkg::FMT_RGB565: begin
            conv_pixel  = {16'd0, r[7:3], g[7:2], b[7:3]};
         end
         pfc_pkg::FMT_A8: begin
            conv_pixel  = {24'd0, a};
            conv_nbytes = 3'd1;
            ok          = ok && has_alpha;
         end
         pfc_pkg::FMT_RGBA4444: begin
            conv_pixel  = {16'd0, r[7:4], g[7:4], b[7:4],
                           has_alpha ? a[7:4] : 4'hF};
         end
         pfc_pkg::FMT_RGB5A1: begin
            conv_pixel  = {16'd0, r[7:3], g[7:3], b[7:3],
                           has_alpha ? a[7] : 1'b1};
         end
         default: begin
            ok = 1'b0;
         end
      endcase
   end

   always_comb begin
      case (src_format)
         pfc_pkg::SRC_I8:     copy_pixel = {24'd0, b0};
         pfc_pkg::SRC_AI88:   copy_pixel = {16'd0, b1, b0};
         pfc_pkg::SRC_RGB888: copy_pixel = {8'd0, b2, b1, b0};
         default:             copy_pixel = src_bytes;
      endcase
   end

   always_comb begin
      if (ok) begin
         result.pixel  = conv_pixel;
         result.nbytes = conv_nbytes;
         result.format = tgt_format[2:0];
         result.passed = 1'b0;
      end else begin
         result.pixel  = copy_pixel;
         result.nbytes = {1'b0, src_format} + 3'd1;
         result.format = {1'b0, src_format};
         result.passed = 1'b1;
      end
   end

endmodule

@@ rtl/core/pixel_format_converter.sv @@
// ----------------------------------------------------------------------------
// Pixel format converter
// An accepted input word passes the input, luma sum and result registers.
// Throughput: one pixel per cycle; three pipeline stages (input, luma sum,
// result), each advancing whenever the stage after it is free or draining.
// Reset clears all stage valids and sets the source format to RGBA8888 and
// the target format to AUTO.
// ----------------------------------------------------------------------------
module pixel_format_converter (
   input  logic        clock,
   input  logic        reset,
   // configuration write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [3:0]  csr_data,
   // input pixels
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // byte_zero, byte_one, byte_two, byte_three
   input  logic        req_tlast,
   // converted pixels
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // out_pixel[31:0], out_bytes[34:32], zero pad
   output logic [3:0]  rsp_tuser,   // out_format[2:0], passed_through[3]
   output logic        rsp_tlast
);

   localparam int SUM_W = pfc_pkg::LUMA_SUM_W;

   logic [1:0]   src_format_ff, src_format_in;
   logic [3:0]   tgt_format_ff, tgt_format_in;

   logic         s0_valid_ff, s0_valid_in;
   logic [31:0]  s0_data_ff, s0_data_in;
   logic         s0_last_ff, s0_last_in;

   logic         s1_valid_ff, s1_valid_in;
   logic [31:0]  s1_data_ff, s1_data_in;
   logic         s1_last_ff, s1_last_in;
   logic [SUM_W-1:0] s1_sum_ff, s1_sum_in;

   logic         out_valid_ff, out_valid_in;
   pfc_pkg::pfc_result_type out_result_ff, out_result_in;
   logic         out_last_ff, out_last_in;

   logic         req_fire, s0_move, s1_move, out_open, s1_open;
   logic [7:0]   r, g, b;
   logic [SUM_W-1:0] luma_sum;
   pfc_pkg::pfc_result_type conv_result;

   assign csr_ready = 1'b1;

   always_comb begin
      src_format_in = src_format_ff;
      tgt_format_in = tgt_format_ff;
      if (csr_valid) begin
         unique case (csr_index)
            pfc_pkg::CSR_SOURCE_FORMAT: src_format_in = csr_data[1:0];
            pfc_pkg::CSR_TARGET_FORMAT: tgt_format_in = csr_data;
            default: ;
         endcase
      end
   end

   // advance control
   assign out_open   = !out_valid_ff || rsp_tready;
   assign s1_open    = !s1_valid_ff || out_open;
   assign req_tready = !s0_valid_ff || s1_open;
   assign req_fire   = req_tvalid && req_tready;
   assign s0_move    = s0_valid_ff && s1_open;
   assign s1_move    = s1_valid_ff && out_open;

   // luma sum on the expanded source color
   always_comb begin
      r = s0_data_ff[7:0];
      if (src_format_ff == pfc_pkg::SRC_I8 || src_format_ff == pfc_pkg::SRC_AI88) begin
         g = s0_data_ff[7:0];
         b = s0_data_ff[7:0];
      end else begin
         g = s0_data_ff[15:8];
         b = s0_data_ff[23:16];
      end
   end

   assign luma_sum = SUM_W'(r) * SUM_W'(pfc_pkg::LUMA_COEF_R)
                   + SUM_W'(g) * SUM_W'(pfc_pkg::LUMA_COEF_G)
                   + SUM_W'(b) * SUM_W'(pfc_pkg::LUMA_COEF_B)
                   + SUM_W'(pfc_pkg::LUMA_ROUND);

   pfc_format u_format (
      .src_format (src_format_ff),
      .tgt_format (tgt_format_ff),
      .src_bytes  (s1_data_ff),
      .luma_sum   (s1_sum_ff),
      .result     (conv_result)
   );

   always_comb begin
      s0_valid_in = s0_valid_ff;
      s0_data_in  = s0_data_ff;
      s0_last_in  = s0_last_ff;
      if (req_fire) begin
         s0_valid_in = 1'b1;
         s0_data_in  = req_tdata;
         s0_last_in  = req_tlast;
      end else if (s0_move) begin
         s0_valid_in = 1'b0;
      end

      s1_valid_in = s1_valid_ff;
      s1_data_in  = s1_data_ff;
      s1_last_in  = s1_last_ff;
      s1_sum_in   = s1_sum_ff;
      if (s0_move) begin
         s1_valid_in = 1'b1;
         s1_data_in  = s0_data_ff;
         s1_last_in  = s0_last_ff;
         s1_sum_in   = luma_sum;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end

      out_valid_in  = out_valid_ff;
      out_result_in = out_result_ff;
      out_last_in   = out_last_ff;
      if (s1_move) begin
         out_valid_in  = 1'b1;
         out_result_in = conv_result;
         out_last_in   = s1_last_ff;
      end else if (rsp_tready) begin
         out_valid_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_format_ff <= pfc_pkg::SRC_RGBA8888;
         tgt_format_ff <= pfc_pkg::FMT_AUTO;
         s0_valid_ff   <= 1'b0;
         s1_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         src_format_ff <= src_format_in;
         tgt_format_ff <= tgt_format_in;
         s0_valid_ff   <= s0_valid_in;
         s1_valid_ff   <= s1_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s0_data_ff    <= s0_data_in;
      s0_last_ff    <= s0_last_in;
      s1_data_ff    <= s1_data_in;
      s1_last_ff    <= s1_last_in;
      s1_sum_ff     <= s1_sum_in;
      out_result_ff <= out_result_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'd0, out_result_ff.nbytes, out_result_ff.pixel};
   assign rsp_tuser  = {out_result_ff.passed, out_result_ff.format};
   assign rsp_tlast  = out_last_ff;

endmodule

@@ bench/tb_pixel_format_converter.sv @@
// ----------------------------------------------------------------------------
// Pixel format converter testbench
// Runs a short table of directed pixels, then random pixels for every
// source and target register setting, under shifting sender and receiver
// back-pressure. Each accepted pixel queues its converted word; every
// result word is compared field by field against the oldest queued word.
// ----------------------------------------------------------------------------
module tb_pixel_format_converter;

   localparam logic [3:0] FMT_CODE_MAX  = 4'd15;
   localparam int         DRAIN_CYCLES  = 8;
   localparam int         SEGMENT_WORDS = 28;
   localparam int         DIR_ROWS      = 26;

   typedef struct packed {
      pfc_pkg::pfc_result_type res;
      logic                    last;
   } pixel_word_type;

   typedef struct packed {
      logic [1:0]  src;
      logic [3:0]  tgt;
      logic [31:0] word;
      logic        last;
      logic        known;
      logic [31:0] exp_pixel;
      logic [2:0]  exp_bytes;
      logic [3:0]  exp_format;
      logic        exp_passed;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = pfc_pkg::CSR_SOURCE_FORMAT;
   logic [3:0]  csr_data = 4'd0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = 32'd0;   // byte_zero, byte_one, byte_two, byte_three
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;           // out_pixel[31:0], out_bytes[34:32], zero pad
   logic [3:0]  rsp_tuser;           // out_format[2:0], passed_through[3]
   logic        rsp_tlast;

   pixel_word_type pixel_expect_q [$];
   int          errors = 0;
   int          send_idle_pct = 22;
   int          recv_idle_pct = 48;
   logic [1:0]  cur_src = pfc_pkg::SRC_RGBA8888;
   logic [3:0]  cur_tgt = pfc_pkg::FMT_AUTO;

   dir_row_type directed_rows [DIR_ROWS] = '{
      '{pfc_pkg::SRC_RGBA8888, pfc_pkg::FMT_AUTO,     32'h44332211, 1'b0, 1'b1,
        32'h44332211, 3'd4, pfc_pkg::FMT_RGBA8888, 1'b1},
      '{pfc_pkg::SRC_RGBA8888, pfc_pkg::FMT_RGBA8888, 32'hFFFFFFFF, 1'b1, 1'b1,
        32'hFFFFFFFF, 3'd4, pfc_pkg::FMT_RGBA8888, 1'b1},
      '{pfc_pkg::SRC_RGBA8888, FMT_CODE_MAX,          32'h00000000, 1'b0, 1'b1,
        32'h00000000, 3'd4, pfc_pkg::FMT_RGBA8888, 1'b1},
      '{pfc_pkg::SRC_RGBA8888, pfc_pkg::FMT_RGB565,   32'hFFFFFFFF, 1'b0, 1'b1,
        32'h0000FFFF, 3'd2, pfc_pkg::FMT_RGB565, 1'b0},
      '{pfc_pkg::SRC_RGBA8888, pfc_pkg::FMT_RGBA4444, 32'h00000000, 1'b0, 1'b1,
        32'h00000000, 3'd2, pfc_pkg::FMT_RGBA4444, 1'b0},
      '{pfc_pkg::SRC_RGBA8888, pfc_pkg::FMT_RGB5A1,   32'h80C0A040, 1'b0, 1'b0,
        32'h0, 3'd0, pfc_pkg::FMT_I8, 1'b0},
      '{pfc_pkg::SRC_RGBA8888, pfc_pkg::FMT_RGB5A1,   32'h7F1F3F5F, 1'b1, 1'b0,
        32'h0, 3'd0, pfc_pkg::FMT_I8, 1'b0},
      '{pfc_pkg::SRC_RGBA8888, pfc_pkg::FMT_I8,       32'h12345678, 1'b0, 1'b0,
        32'h0, 3'd0, pfc_pkg::FMT_I8, 1'b0},
      '{pfc_pkg::SRC_RGBA8888, pfc_pkg::FMT_AI88,     32'hC0FFEE42, 1'b0, 1'b0,
        32'h0, 3'd0, pfc_pkg::FMT_I8, 1'b0},
      '{pfc_pkg::SRC_RGBA8888, pfc_pkg::FMT_A8,       32'hA5000000, 1'b0, 1'b1,
        32'h000000A5, 3'd1, pfc_pkg::FMT_A8, 1'b0},
      '{pfc_pkg::SRC_RGB888,   pfc_pkg::FMT_I8,       32'hAAFFFFFF, 1'b0, 1'b1,
        32'h000000FF, 3'd1, pfc_pkg::FMT_I8, 1'b0},
      '{pfc_pkg::SRC_RGB888,   pfc_pkg::FMT_I8,       32'hFF000000, 1'b1, 1'b1,
        32'h00000000, 3'd1, pfc_pkg::FMT_I8, 1'b0},
      '{pfc_pkg::SRC_RGB888,   pfc_pkg::FMT_A8,       32'h04030201, 1'b0, 1'b1,
        32'h00030201, 3'd3, pfc_pkg::FMT_RGB888, 1'b1},
      '{pfc_pkg::SRC_RGB888,   pfc_pkg::FMT_RGB5A1,   32'h00FFFFFF, 1'b0, 1'b1,
        32'h0000FFFF, 3'd2, pfc_pkg::FMT_RGB5A1, 1'b0},
      '{pfc_pkg::SRC_RGB888,   pfc_pkg::FMT_RGBA4444, 32'hFF000000, 1'b0, 1'b1,
        32'h0000000F, 3'd2, pfc_pkg::FMT_RGBA4444, 1'b0},
      '{pfc_pkg::SRC_RGB888,   pfc_pkg::FMT_AI88,     32'h00306090, 1'b0, 1'b0,
        32'h0, 3'd0, pfc_pkg::FMT_I8, 1'b0},
      '{pfc_pkg::SRC_RGB888,   pfc_pkg::FMT_RGBA8888, 32'h55112233, 1'b0, 1'b0,
        32'h0, 3'd0, pfc_pkg::FMT_I8, 1'b0},
      '{pfc_pkg::SRC_I8,       pfc_pkg::FMT_A8,       32'hFFEEDDAB, 1'b0, 1'b1,
        32'h000000AB, 3'd1, pfc_pkg::FMT_I8, 1'b1},
      '{pfc_pkg::SRC_I8,       pfc_pkg::FMT_AUTO,     32'h00000001, 1'b1, 1'b1,
        32'h00000001, 3'd1, pfc_pkg::FMT_I8, 1'b1},
      '{pfc_pkg::SRC_I8,       pfc_pkg::FMT_RGBA8888, 32'h77665580, 1'b0, 1'b1,
        32'hFF808080, 3'd4, pfc_pkg::FMT_RGBA8888, 1'b0},
      '{pfc_pkg::SRC_I8,       pfc_pkg::FMT_RGB565,   32'h000000FF, 1'b0, 1'b0,
        32'h0, 3'd0, pfc_pkg::FMT_I8, 1'b0},
      '{pfc_pkg::SRC_I8,       pfc_pkg::FMT_RGB5A1,   32'h0000007F, 1'b0, 1'b0,
        32'h0, 3'd0, pfc_pkg::FMT_I8, 1'b0},
      '{pfc_pkg::SRC_AI88,     pfc_pkg::FMT_I8,       32'hDDCC337E, 1'b0, 1'b1,
        32'h0000007E, 3'd1, pfc_pkg::FMT_I8, 1'b0},
      '{pfc_pkg::SRC_AI88,     pfc_pkg::FMT_A8,       32'h0000337E, 1'b0, 1'b1,
        32'h00000033, 3'd1, pfc_pkg::FMT_A8, 1'b0},
      '{pfc_pkg::SRC_AI88,     FMT_CODE_MAX,          32'h9988A55A, 1'b1, 1'b1,
        32'h0000A55A, 3'd2, pfc_pkg::FMT_AI88, 1'b1},
      '{pfc_pkg::SRC_AI88,     pfc_pkg::FMT_RGBA4444, 32'h0000F0F0, 1'b0, 1'b0,
        32'h0, 3'd0, pfc_pkg::FMT_I8, 1'b0}
   };

   pixel_format_converter i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #10 clock = ~clock;

   function automatic pixel_word_type convert_pixel(input logic [1:0] src,
                                                    input logic [3:0] tgt,
                                                    input logic [31:0] word,
                                                    input logic last);
      int unsigned    r, g, b, a, lum, pix, nb;
      logic           has_alpha, ok;
      pixel_word_type w;
      r = 32'(word[7:0]);
      g = 32'(word[15:8]);
      b = 32'(word[23:16]);
      a = 32'(word[31:24]);
      has_alpha = 1'b1;
      case (src)
         pfc_pkg::SRC_I8: begin
            g = r;
            b = r;
            a = 255;
            has_alpha = 1'b0;
         end
         pfc_pkg::SRC_AI88: begin
            a = 32'(word[15:8]);
            g = r;
            b = r;
         end
         pfc_pkg::SRC_RGB888: begin
            a = 255;
            has_alpha = 1'b0;
         end
         default: ;
      endcase
      lum = (r * 299 + g * 587 + b * 114 + 500) / 1000;
      ok  = (tgt != {2'b00, src}) && (tgt <= pfc_pkg::FMT_RGB5A1);
      pix = 0;
      nb  = 0;
      if (ok) begin
         case (tgt)
            pfc_pkg::FMT_I8: begin
               pix = (src == pfc_pkg::SRC_AI88) ? r : lum;
               nb  = 1;
            end
            pfc_pkg::FMT_AI88: begin
               pix = ((src == pfc_pkg::SRC_I8 || src == pfc_pkg::SRC_AI88) ? r : lum)
                     | (a << 8);
               nb  = 2;
            end
            pfc_pkg::FMT_RGB888: begin
               pix = r | (g << 8) | (b << 16);
               nb  = 3;
            end
            pfc_pkg::FMT_RGBA8888: begin
               pix = r | (g << 8) | (b << 16) | (a << 24);
               nb  = 4;
            end
            pfc_pkg::FMT_RGB565: begin
               pix = ((r & 'hF8) << 8) | ((g & 'hFC) << 3) | ((b & 'hF8) >> 3);
               nb  = 2;
            end
            pfc_pkg::FMT_A8: begin
               if (!has_alpha) begin
                  ok = 1'b0;
               end else begin
                  pix = a;
                  nb  = 1;
               end
            end
            pfc_pkg::FMT_RGBA4444: begin
               pix = ((r & 'hF0) << 8) | ((g & 'hF0) << 4) | (b & 'hF0)
                     | (has_alpha ? ((a & 'hF0) >> 4) : 'hF);
               nb  = 2;
            end
            default: begin
               pix = ((r & 'hF8) << 8) | ((g & 'hF8) << 3) | ((b & 'hF8) >> 2)
                     | (has_alpha ? ((a & 'h80) >> 7) : 1);
               nb  = 2;
            end
         endcase
      end
      if (!ok) begin
         case (src)
            pfc_pkg::SRC_I8: begin
               pix = 32'(word[7:0]);
               nb  = 1;
            end
            pfc_pkg::SRC_AI88: begin
               pix = 32'(word[15:0]);
               nb  = 2;
            end
            pfc_pkg::SRC_RGB888: begin
               pix = 32'(word[23:0]);
               nb  = 3;
            end
            default: begin
               pix = word;
               nb  = 4;
            end
         endcase
      end
      w.res.pixel  = pix;
      w.res.nbytes = nb[2:0];
      w.res.format = ok ? tgt[2:0] : {1'b0, src};
      w.res.passed = !ok;
      w.last       = last;
      return w;
   endfunction

   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      while (pixel_expect_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic program_formats(input logic [1:0] src, input logic [3:0] tgt);
      csr_valid <= 1'b1;
      csr_index <= pfc_pkg::CSR_SOURCE_FORMAT;
      csr_data  <= {2'b00, src};
      do @(posedge clock); while (!csr_ready);
      csr_index <= pfc_pkg::CSR_TARGET_FORMAT;
      csr_data  <= tgt;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cur_src = src;
      cur_tgt = tgt;
   endtask

   task automatic send_pixel(input pixel_word_type exp, input logic [31:0] word,
                             input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      pixel_expect_q.push_back(exp);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      pixel_word_type exp;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pixel_expect_q.size() == 0) begin
            $display("%0t: unexpected word, expected none, actual pixel %h", $time,
                     rsp_tdata[31:0]);
            errors++;
         end else begin
            exp = pixel_expect_q.pop_front();
            if (rsp_tdata[31:0] !== exp.res.pixel) begin
               $display("%0t: out_pixel expected %h actual %h", $time,
                        exp.res.pixel, rsp_tdata[31:0]);
               errors++;
            end
            if (rsp_tdata[34:32] !== exp.res.nbytes) begin
               $display("%0t: out_bytes expected %0d actual %0d", $time,
                        exp.res.nbytes, rsp_tdata[34:32]);
               errors++;
            end
            if (rsp_tuser[2:0] !== exp.res.format) begin
               $display("%0t: out_format expected %0d actual %0d", $time,
                        exp.res.format, rsp_tuser[2:0]);
               errors++;
            end
            if (rsp_tuser[3] !== exp.res.passed) begin
               $display("%0t: passed_through expected %b actual %b", $time,
                        exp.res.passed, rsp_tuser[3]);
               errors++;
            end
            if (rsp_tlast !== exp.last) begin
               $display("%0t: last_out expected %b actual %b", $time,
                        exp.last, rsp_tlast);
               errors++;
            end
         end
      end
   end

   initial begin
      dir_row_type    row;
      pixel_word_type exp;
      logic [31:0]    word;
      logic           last;
      int             seg;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < DIR_ROWS; i++) begin
         row = directed_rows[i];
         if (row.src != cur_src || row.tgt != cur_tgt) begin
            wait_for_drain();
            program_formats(row.src, row.tgt);
         end
         if (row.known) begin
            exp.res.pixel  = row.exp_pixel;
            exp.res.nbytes = row.exp_bytes;
            exp.res.format = row.exp_format[2:0];
            exp.res.passed = row.exp_passed;
            exp.last       = row.last;
         end else begin
            exp = convert_pixel(cur_src, cur_tgt, row.word, row.last);
         end
         send_pixel(exp, row.word, row.last);
      end

      seg = 0;
      for (int s = 0; s < 4; s++) begin
         for (int t = 0; t < 16; t++) begin
            if (seg == 22) begin
               send_idle_pct = 48;
               recv_idle_pct = 22;
            end else if (seg == 43) begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
            wait_for_drain();
            program_formats(s[1:0], t[3:0]);
            repeat (SEGMENT_WORDS) begin
               for (int k = 0; k < 4; k++) begin
                  case ($urandom_range(7))
                     0: word[8*k +: 8] = 8'h00;
                     1: word[8*k +: 8] = 8'hFF;
                     default: word[8*k +: 8] = 8'($urandom_range(255));
                  endcase
               end
               last = ($urandom_range(15) == 0);
               exp  = convert_pixel(cur_src, cur_tgt, word, last);
               send_pixel(exp, word, last);
            end
            seg++;
         end
      end

      wait_for_drain();
      if (errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
